FILE: src/multichannel_ring_delay_line_macros.svh
// Assertion macros for the multichannel ring delay line.
// Included by the RTL files that carry concurrent checks; needs nothing else.
`ifndef MULTICHANNEL_RING_DELAY_LINE_MACROS_SVH
`define MULTICHANNEL_RING_DELAY_LINE_MACROS_SVH
`ifndef SYNTHESIS
// Check sampled on the rising clock edge, suspended while reset is low.
`define MRDL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check sampled on every rising clock edge, reset included.
`define MRDL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MRDL_ASSERT(lbl, clk, rst_n, prop, msg)
`define MRDL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: src/mrdl_pkg.sv
// Shared types and constants of the multichannel ring delay line.
// No dependencies; imported by mrdl_front, mrdl_back and the top level.
package mrdl_pkg;

    localparam int CHAN_W      = 3;
    localparam int SAMPLE_W    = 32;
    localparam int DLY_REG_W   = 13;
    localparam int CHN_REG_W   = 4;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY    = 1'b0,
        CFG_CHANNELS = 1'b1
    } cfg_idx_t;

    // Status from the back end to the front end
    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

FILE: src/mrdl_front.sv
// Front end: config registers, write position and item classification.
// Depends on mrdl_pkg and the assertion macro header.
`include "multichannel_ring_delay_line_macros.svh"
module mrdl_front #(
    parameter int RING_DEPTH   = 4096,
    parameter int MAX_CHANNELS = 8,
    parameter int ADDR_W       = 15
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [mrdl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mrdl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mrdl_pkg::CHAN_W-1:0]       s_chan,
    input  logic [mrdl_pkg::SAMPLE_W-1:0]     s_sample_in,
    input  logic                              s_frame_end,
    input  mrdl_pkg::back_status_t            back_status,
    output logic                              q_push,
    input  logic                              q_ready,
    output logic                              q_mem_en,
    output logic [mrdl_pkg::CHAN_W-1:0]       q_chan,
    output logic [mrdl_pkg::SAMPLE_W-1:0]     q_word,
    output logic [ADDR_W-1:0]                 q_rd_addr,
    output logic [ADDR_W-1:0]                 q_wr_addr
);
    import mrdl_pkg::*;

    localparam int POS_W    = $clog2(RING_DEPTH);
    localparam int RING_CAP = 1 << POS_W;
    localparam int DLY_W    = (POS_W + 1 > DLY_REG_W) ? POS_W + 1 : DLY_REG_W;
    localparam int MAXC_W   = $clog2(MAX_CHANNELS + 1);
    localparam int CMP_W    = (MAXC_W > CHN_REG_W) ? MAXC_W : CHN_REG_W;

    logic [DLY_REG_W-1:0] delay_reg,  delay_next;
    logic [CHN_REG_W-1:0] chans_reg,  chans_next;
    logic [POS_W-1:0]     wpos_reg,   wpos_next;

    logic [DLY_W-1:0]     delay_ext;
    logic [POS_W-1:0]     delay_low;
    logic                 delay_nz;
    logic                 chan_used;
    logic                 accept;
    logic [POS_W-1:0]     rd_pos;

    // config writes
    always_comb begin
        delay_next = delay_reg;
        chans_next = chans_reg;
        if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_DELAY:    delay_next = cfg_wdata[DLY_REG_W-1:0];
                CFG_CHANNELS: chans_next = cfg_wdata[CHN_REG_W-1:0];
                default: begin
                    delay_next = delay_reg;
                end
            endcase
        end
    end

    // saturate delay to ring capacity; a full-capacity delay has zero low bits
    assign delay_ext = DLY_W'(delay_reg);
    assign delay_nz  = (delay_reg != '0);
    assign delay_low = (delay_ext > DLY_W'(RING_CAP)) ? '0 : delay_ext[POS_W-1:0];

    assign chan_used = (CMP_W'(s_chan) < CMP_W'(chans_reg)) &&
                       (CMP_W'(s_chan) < CMP_W'(MAX_CHANNELS));

    assign s_ready = q_ready && !back_status.clearing;
    assign accept  = s_valid && s_ready;

    assign rd_pos    = wpos_reg - delay_low;
    assign q_push    = accept;
    assign q_mem_en  = delay_nz && chan_used;
    assign q_chan    = s_chan;
    assign q_word    = s_sample_in;
    assign q_rd_addr = (ADDR_W'(s_chan) << POS_W) | ADDR_W'(rd_pos);
    assign q_wr_addr = (ADDR_W'(s_chan) << POS_W) | ADDR_W'(wpos_reg);

    assign wpos_next = (accept && s_frame_end && delay_nz) ? wpos_reg + 1'b1 : wpos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= '0;
            chans_reg <= CHN_REG_W'(1);
            wpos_reg  <= '0;
        end else begin
            delay_reg <= delay_next;
            chans_reg <= chans_next;
            wpos_reg  <= wpos_next;
        end
    end

    `MRDL_ASSERT(a_wpos_step, aclk, aresetn, ($past(aresetn) && wpos_reg != $past(wpos_reg)) |-> $past(accept && s_frame_end && delay_nz), "write position moved without a frame end beat")

endmodule

FILE: src/mrdl_queue.sv
// Two-entry decoupling queue between front and back end.
// Depends on the assertion macro header only.
`include "multichannel_ring_delay_line_macros.svh"
module mrdl_queue #(
    parameter int WIDTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       cnt_reg,  cnt_next;
    logic             push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = slot_reg[rptr_reg];
    assign push     = wr_en && wr_ready;
    assign pop      = rd_en && rd_valid;

    assign wptr_next = push ? ~wptr_reg : wptr_reg;
    assign rptr_next = pop  ? ~rptr_reg : rptr_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    `MRDL_ASSERT(a_q_count, aclk, aresetn, (cnt_reg != 2'd3) && ((cnt_reg == 2'd1) == (wptr_reg != rptr_reg)), "queue count and pointers disagree")

endmodule

FILE: src/mrdl_back.sv
// Back end: ring memory, read-then-write per item, output register, clear sweep.
// Depends on mrdl_pkg and the assertion macro header.
`include "multichannel_ring_delay_line_macros.svh"
module mrdl_back #(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_pop,
    input  logic                           q_mem_en,
    input  logic [mrdl_pkg::CHAN_W-1:0]    q_chan,
    input  logic [mrdl_pkg::SAMPLE_W-1:0]  q_word,
    input  logic [ADDR_W-1:0]              q_rd_addr,
    input  logic [ADDR_W-1:0]              q_wr_addr,
    output mrdl_pkg::back_status_t         back_status,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mrdl_pkg::CHAN_W-1:0]    m_chan_out,
    output logic [mrdl_pkg::SAMPLE_W-1:0]  m_sample_out
);
    import mrdl_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];

    logic                clearing_reg, clearing_next;
    logic [ADDR_W-1:0]   clr_cnt_reg,  clr_cnt_next;
    logic                mvalid_reg,   mvalid_next;
    logic [CHAN_W-1:0]   chan_reg;
    logic [SAMPLE_W-1:0] word_reg;
    logic                byp_reg;
    logic [SAMPLE_W-1:0] rdata_reg;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [SAMPLE_W-1:0] mem_wdata;
    logic                rd_en;
    logic                clr_last;

    assign q_pop   = q_valid && !clearing_reg && (!mvalid_reg || m_ready);
    assign rd_en   = q_pop && q_mem_en;
    assign clr_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));

    assign mem_we    = clearing_reg || rd_en;
    assign mem_waddr = clearing_reg ? clr_cnt_reg : q_wr_addr;
    assign mem_wdata = clearing_reg ? '0 : q_word;

    // read-first: same-address read returns the old word
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[q_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            chan_reg <= q_chan;
            word_reg <= q_word;
            byp_reg  <= !q_mem_en;
        end
    end

    assign clearing_next = clearing_reg && !clr_last;
    assign clr_cnt_next  = clearing_reg ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
    assign mvalid_next   = q_pop ? 1'b1 : (m_ready ? 1'b0 : mvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            mvalid_reg   <= 1'b0;
        end else begin
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
            mvalid_reg   <= mvalid_next;
        end
    end

    assign back_status.clearing = clearing_reg;
    assign m_valid      = mvalid_reg;
    assign m_chan_out   = chan_reg;
    assign m_sample_out = byp_reg ? word_reg : rdata_reg;

    `MRDL_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> clearing_reg, "reset did not start the clear sweep")
    `MRDL_ASSERT(a_no_pop_clear, aclk, aresetn, clearing_reg |-> !q_pop, "item taken during clear sweep")
    `MRDL_ASSERT(a_clear_done, aclk, aresetn, $fell(clearing_reg) |-> $past(clr_last), "clear sweep ended early")

endmodule

FILE: src/multichannel_ring_delay_line.sv
// Top level of the multichannel ring delay line.
// Depends on mrdl_pkg, mrdl_front, mrdl_queue and mrdl_back.
//
// Usage:
//   s_* channel: one beat carries one sample word for one channel; s_frame_end
//   marks the last channel of a frame and, with a nonzero delay, moves the shared write position.
//   m_* channel: exactly one beat per input beat, in order; m_chan_out echoes
//   the channel and m_sample_out holds the word written delay frames earlier,
//   or the input word for a bypassed beat (zero delay or channel not in use).
//   cfg_*: register 0 is delay_samples, register 1 is channels_in_use; write
//   only while the block holds no beat in flight.
// Path: an accepted beat is written to a queue slot, then popped into the
//   memory read and the output register.
// Throughput: one beat per cycle when not stalled, set by the ring memory doing
//   one read and one write per cycle; the front end keeps accepting while a result waits.
// Reset: a clear sweep zeroes the rings, one word per cycle, over all
//   MAX_CHANNELS * RING_CAP words (32768 with the defaults, RING_CAP being
//   RING_DEPTH rounded up to a power of two); s_ready stays low meanwhile.
// Stall: when m_ready is low the output register holds; the two-entry queue
//   fills and then s_ready drops.
module multichannel_ring_delay_line #(
    parameter int RING_DEPTH   = 4096,
    parameter int MAX_CHANNELS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [mrdl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mrdl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input beats
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mrdl_pkg::CHAN_W-1:0]       s_chan,
    input  logic [mrdl_pkg::SAMPLE_W-1:0]     s_sample_in,
    input  logic                              s_frame_end,
    // result beats
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mrdl_pkg::CHAN_W-1:0]       m_chan_out,
    output logic [mrdl_pkg::SAMPLE_W-1:0]     m_sample_out
);
    import mrdl_pkg::*;

    localparam int POS_W    = $clog2(RING_DEPTH);
    localparam int RING_CAP = 1 << POS_W;
    localparam int DEPTH    = MAX_CHANNELS * RING_CAP;
    localparam int ADDR_W   = $clog2(DEPTH);
    // queue entry: mem enable, channel, word, read address, write address
    localparam int Q_W      = 1 + CHAN_W + SAMPLE_W + 2 * ADDR_W;

    back_status_t        back_status;

    // front -> queue
    logic                f_push;
    logic                f_ready;
    logic                f_mem_en;
    logic [CHAN_W-1:0]   f_chan;
    logic [SAMPLE_W-1:0] f_word;
    logic [ADDR_W-1:0]   f_rd_addr;
    logic [ADDR_W-1:0]   f_wr_addr;
    logic [Q_W-1:0]      f_data;

    // queue -> back
    logic                b_valid;
    logic                b_pop;
    logic [Q_W-1:0]      b_data;
    logic                b_mem_en;
    logic [CHAN_W-1:0]   b_chan;
    logic [SAMPLE_W-1:0] b_word;
    logic [ADDR_W-1:0]   b_rd_addr;
    logic [ADDR_W-1:0]   b_wr_addr;

    mrdl_front #(
        .RING_DEPTH   (RING_DEPTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_chan      (s_chan),
        .s_sample_in (s_sample_in),
        .s_frame_end (s_frame_end),
        .back_status (back_status),
        .q_push      (f_push),
        .q_ready     (f_ready),
        .q_mem_en    (f_mem_en),
        .q_chan      (f_chan),
        .q_word      (f_word),
        .q_rd_addr   (f_rd_addr),
        .q_wr_addr   (f_wr_addr)
    );

    assign f_data = {f_mem_en, f_chan, f_word, f_rd_addr, f_wr_addr};

    mrdl_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (f_push),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (b_valid),
        .rd_en    (b_pop),
        .rd_data  (b_data)
    );

    assign {b_mem_en, b_chan, b_word, b_rd_addr, b_wr_addr} = b_data;

    mrdl_back #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (b_valid),
        .q_pop        (b_pop),
        .q_mem_en     (b_mem_en),
        .q_chan       (b_chan),
        .q_word       (b_word),
        .q_rd_addr    (b_rd_addr),
        .q_wr_addr    (b_wr_addr),
        .back_status  (back_status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_chan_out   (m_chan_out),
        .m_sample_out (m_sample_out)
    );

endmodule
